/* rtl/core/hfs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_pkg: shared types and constants for the half-float to sRGB converter
// Holds the lane configuration and passthrough types, register indexes and
// the sRGB encoding threshold table, built at elaboration.
// ----------------------------------------------------------------------------
package hfs_pkg;

  localparam int unsigned LANE_COUNT = 3;
  // One decode/scale stage, one shift stage and eight search stages.
  localparam int unsigned LANE_DEPTH = 10;

  localparam logic MODE_HALF = 1'b0;
  localparam logic MODE_BYTE = 1'b1;

  localparam logic REG_FORMAT_MODE   = 1'b0;
  localparam logic REG_INVERSE_WHITE = 1'b1;

  localparam logic [24:0] ONE_Q24 = 25'h100_0000;
  localparam logic [7:0]  PAD_BYTE = 8'hFF;

  typedef struct packed {
    logic        mode;
    logic [15:0] inv_white;
  } hfs_lane_cfg_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
  } hfs_pass_t;

  typedef logic [24:0] thr_tab_t [256];

  // Entry k is the smallest 1.24 linear value whose encoded byte is at least k.
  // The power segment is solved exactly as L^5 * 538050^12 >= N^12 * 2^120.
  function automatic thr_tab_t thr_build();
    thr_tab_t     tab;
    logic [383:0] den;
    logic [383:0] rhs;
    logic [383:0] lhs;
    logic [63:0]  num;
    logic [31:0]  nk;
    logic [24:0]  lo;
    logic [24:0]  hi;
    logic [24:0]  mid;
    tab[0] = '0;
    for (int k = 1; k <= 10; k++) begin
      num = 64'((2 * k - 1) * 10) << 24;
      tab[k] = 25'((num + 64'd65891) / 64'd65892);
    end
    den = 384'd1;
    for (int i = 0; i < 12; i++) begin
      den = den * 384'd538050;
    end
    for (int k = 11; k <= 255; k++) begin
      nk = 32'((2 * k - 1) * 1000 + 28050);
      rhs = 384'd1;
      for (int i = 0; i < 12; i++) begin
        rhs = rhs * 384'(nk);
      end
      rhs = rhs << 120;
      lo = '0;
      hi = ONE_Q24;
      for (int it = 0; it < 26; it++) begin
        if (lo < hi) begin
          mid = lo + ((hi - lo) >> 1);
          lhs = den;
          for (int j = 0; j < 5; j++) begin
            lhs = lhs * 384'(mid);
          end
          if (lhs >= rhs) begin
            hi = mid;
          end else begin
            lo = mid + 25'd1;
          end
        end
      end
      tab[k] = lo;
    end
    return tab;
  endfunction

  localparam thr_tab_t THR_TAB = thr_build();

endpackage

/* rtl/core/hfs_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_lane: one color channel of the converter
// Decodes a half, scales it by the inverse white level, saturates to 1.0 and
// finds the sRGB byte by an eight-stage binary search of the threshold table.
// ----------------------------------------------------------------------------
module hfs_lane (
  input  logic                  clk,
  input  logic                  en,
  input  logic [15:0]           chan_i,
  input  logic [7:0]            pass_i,
  input  hfs_pkg::hfs_lane_cfg_t cfg_i,
  output logic [7:0]            byte_o
);
  import hfs_pkg::*;

  // Decode and multiply
  logic [4:0]  ex;
  logic [9:0]  fr;
  logic        special;
  logic [10:0] mant;
  logic [4:0]  exp_nxt;
  logic        fz_nxt;
  logic        fo_nxt;
  logic [26:0] prod_nxt;

  logic [26:0] prod_r;
  logic [4:0]  exp_r;
  logic        fz_r;
  logic        fo_r;

  logic [44:0] wide;
  logic [24:0] lin_nxt;

  logic [24:0] lin_r [8];
  logic [7:0]  idx_r [9];
  hfs_pass_t   pass_r [LANE_DEPTH];

  always_comb begin
    ex       = chan_i[14:10];
    fr       = chan_i[9:0];
    special  = (ex == 5'd31);
    mant     = (ex == 5'd0) ? {1'b0, fr} : {1'b1, fr};
    exp_nxt  = (ex == 5'd0) ? 5'd1 : ex;
    // NaN, any negative value and infinity with a zero white scale give 0.
    fz_nxt   = chan_i[15] || (special && ((fr != 10'd0) || (cfg_i.inv_white == 16'd0)));
    fo_nxt   = special && !fz_nxt;
    prod_nxt = 27'(mant) * 27'(cfg_i.inv_white);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      exp_r  <= exp_nxt;
      fz_r   <= fz_nxt;
      fo_r   <= fo_nxt;
    end
  end

  // Align the product to 1.24 and saturate at 1.0
  always_comb begin
    if (exp_r >= 5'd13) begin
      wide = {18'd0, prod_r} << (exp_r - 5'd13);
    end else begin
      wide = {18'd0, prod_r >> (5'd13 - exp_r)};
    end
    if (fz_r) begin
      lin_nxt = '0;
    end else if (fo_r || (wide > 45'(ONE_Q24))) begin
      lin_nxt = ONE_Q24;
    end else begin
      lin_nxt = wide[24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lin_r[0] <= lin_nxt;
      idx_r[0] <= '0;
    end
  end

  // Each search stage settles one bit of the byte, most significant first.
  for (genvar s = 0; s < 8; s++) begin : g_srch
    localparam logic [7:0] BIT = 8'(1 << (7 - s));
    logic [7:0] cand;
    assign cand = idx_r[s] | BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        idx_r[s + 1] <= (THR_TAB[cand] <= lin_r[s]) ? cand : idx_r[s];
      end
    end
    if (s < 7) begin : g_lin
      always_ff @(posedge clk) begin
        if (en) begin
          lin_r[s + 1] <= lin_r[s];
        end
      end
    end
  end

  // The raw byte and mode follow the item down the lane.
  always_ff @(posedge clk) begin
    if (en) begin
      pass_r[0] <= '{mode: cfg_i.mode, data: pass_i};
      for (int i = 1; i < LANE_DEPTH; i++) begin
        pass_r[i] <= pass_r[i - 1];
      end
    end
  end

  assign byte_o = (pass_r[LANE_DEPTH - 1].mode == MODE_BYTE) ?
                  pass_r[LANE_DEPTH - 1].data : idx_r[8];

endmodule

/* rtl/core/hfs_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_merge: output word assembly and output register
// Packs the three lane bytes and the pad byte and holds the word until the
// downstream side takes it; tells the lanes when they may advance.
// ----------------------------------------------------------------------------
module hfs_merge (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        vld_i,
  input  logic [7:0]  blue_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  red_i,
  output logic        adv_o,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata
);
  import hfs_pkg::*;

  logic        valid_r;
  logic [31:0] data_r;

  assign adv_o = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv_o) begin
      valid_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o) begin
      data_r <= {PAD_BYTE, red_i, green_i, blue_i};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

/* rtl/core/half_float_to_srgb_pixel.sv */
`timescale 1ns / 1ps
// Each transfer runs through the lanes and the hfs_merge output register.
// Throughput: one pixel per cycle; three channel lanes run side by side and the
// whole pipeline holds while a finished word waits on out_tready.
// Reset (rst_n low, synchronous) empties the pipeline and sets format_mode to 0
// and inverse_white to 4096.
// ----------------------------------------------------------------------------
// half_float_to_srgb_pixel: linear half-float RGB to 8-bit B,G,R,X converter
// Three lanes decode, scale and sRGB-encode one channel each; a merge stage
// packs the bytes into one output word. 8-bit mode passes bytes through.
// ----------------------------------------------------------------------------
module half_float_to_srgb_pixel (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // chan_a [15:0], chan_b [31:16], chan_c [47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // blue_out, green_out, red_out, pad_out
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import hfs_pkg::*;

  logic          format_mode_r;
  logic [15:0]   inv_white_r;
  logic          cfg_wr;
  logic          reg_idx;
  hfs_lane_cfg_t lane_cfg;

  logic          adv;
  logic          vld_r [LANE_DEPTH];
  logic [15:0]   chan [LANE_COUNT];
  logic [7:0]    lane_byte [LANE_COUNT];

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      format_mode_r <= MODE_HALF;
      inv_white_r   <= 16'd4096;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FORMAT_MODE:   format_mode_r <= cfg_pwdata[0];
        REG_INVERSE_WHITE: inv_white_r   <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FORMAT_MODE:   cfg_prdata = {31'd0, format_mode_r};
      REG_INVERSE_WHITE: cfg_prdata = {16'd0, inv_white_r};
      default:           cfg_prdata = '0;
    endcase
  end

  assign lane_cfg  = '{mode: format_mode_r, inv_white: inv_white_r};
  assign in_tready = adv;

  // Lane 0 is blue, lane 1 green, lane 2 red.
  assign chan[0] = in_tdata[47:32];
  assign chan[1] = in_tdata[31:16];
  assign chan[2] = in_tdata[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANE_DEPTH; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (adv) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i < LANE_DEPTH; i++) begin
        vld_r[i] <= vld_r[i - 1];
      end
    end
  end

  // In 8-bit mode the byte order is B,G,R from the lowest field up, so lanes 0
  // and 2 pass the low byte of a different field than the half they decode.
  for (genvar l = 0; l < LANE_COUNT; l++) begin : g_lane
    hfs_lane u_lane (
      .clk    (clk),
      .en     (adv),
      .chan_i (chan[l]),
      .pass_i (in_tdata[16 * l +: 8]),
      .cfg_i  (lane_cfg),
      .byte_o (lane_byte[l])
    );
  end

  hfs_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld_i      (vld_r[LANE_DEPTH - 1]),
    .blue_i     (lane_byte[0]),
    .green_i    (lane_byte[1]),
    .red_i      (lane_byte[2]),
    .adv_o      (adv),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* rtl/core/hfs_port_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfs_port_checker: port-level checks for the converter
// Watches the top-level ports only and is bound to every instance.
// ----------------------------------------------------------------------------
module hfs_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        cfg_pready
);
  import hfs_pkg::*;

  // A word that is not taken stays on the bus unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // Every result carries the fixed pad byte.
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:24] == PAD_BYTE)
    else $error("pad byte is not 0xFF");

  // With no word waiting the block must take input.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while the output is empty");

  // The downstream side taking a word frees the pipeline for input.
  a_ready_taken: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |-> in_tready && cfg_pready)
    else $error("input stalled while the output word is taken");

endmodule

bind half_float_to_srgb_pixel hfs_port_checker u_hfs_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);
